@@ src/prefix_keyed_secret_capture_assert.svh @@
// Assertion macros for the prefix-keyed secret capture block.
// Needs clk_i and rst_ni in the scope of every use.
`ifndef PREFIX_KEYED_SECRET_CAPTURE_ASSERT_SVH
`define PREFIX_KEYED_SECRET_CAPTURE_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define PKSC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define PKSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/pksc_pkg.sv @@
// Package for the prefix-keyed secret capture block: capacity, codes, prefix table.
// No dependencies.
`timescale 1ns / 1ps
package pksc_pkg;

  localparam int unsigned SECRET_CAP = 128;
  localparam int unsigned KEY_LEN    = 9;
  localparam int unsigned LEN_W      = $clog2(SECRET_CAP + 1);
  localparam int unsigned ADDR_W     = $clog2(SECRET_CAP);
  localparam int unsigned IDX_W      = 7;
  localparam int unsigned CMP_W      = (LEN_W > IDX_W) ? LEN_W : IDX_W;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_READ    = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_NOP     = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    MODE_SCAN    = 3'b001,
    MODE_CAPTURE = 3'b010,
    MODE_PASS    = 3'b100
  } mode_e;

  // "password:" one character per position
  function automatic logic [7:0] prefix_char(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = 8'h70;
      4'd1:    ch = 8'h61;
      4'd2:    ch = 8'h73;
      4'd3:    ch = 8'h73;
      4'd4:    ch = 8'h77;
      4'd5:    ch = 8'h6F;
      4'd6:    ch = 8'h72;
      4'd7:    ch = 8'h64;
      4'd8:    ch = 8'h3A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ src/pksc_req_if.sv @@
// Request channel of the prefix-keyed secret capture block.
// Depends on pksc_pkg for the index width.
`timescale 1ns / 1ps
interface pksc_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [7:0]                    data_byte;
  logic                          buffer_last;
  logic [pksc_pkg::IDX_W-1:0]    secret_index;

  modport source (output valid, kind, data_byte, buffer_last, secret_index, input ready);
  modport sink   (input valid, kind, data_byte, buffer_last, secret_index, output ready);
endinterface

@@ src/pksc_res_if.sv @@
// Result channel of the prefix-keyed secret capture block.
// No dependencies.
`timescale 1ns / 1ps
interface pksc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       buffer_end;
  logic       unlock_request;
  logic [7:0] secret_length;

  modport source (output valid, out_byte, run_last, buffer_end, unlock_request,
                  secret_length, input ready);
  modport sink   (input valid, out_byte, run_last, buffer_end, unlock_request,
                  secret_length, output ready);
endinterface

@@ src/prefix_keyed_secret_capture.sv @@
// The first result of an accepted request is registered and shows in the cycle after it is taken.
// It takes one request per cycle while each request yields at most one result and the
// result side is ready; a request that yields several results holds the result stage and
// blocks the request side until its last result is taken. Held prefix bytes yield no result.
// Reset clears scan state, length, unlock flag and the result stage; the secret
// store is not cleared. Depends on pksc_pkg, pksc_req_if, pksc_res_if and the assert header.
`timescale 1ns / 1ps
`include "prefix_keyed_secret_capture_assert.svh"
module prefix_keyed_secret_capture (
  input  logic        clk_i,
  input  logic        rst_ni,
  pksc_req_if.sink    req_i,
  pksc_res_if.source  res_o
);
  import pksc_pkg::*;

  // scan and capture state
  mode_e              mode_q, mode_d;
  logic [3:0]         mc_q, mc_d;
  logic [3:0]         held_q, held_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic               req_flag_q, req_flag_d;

  logic [7:0]         mem [SECRET_CAP];

  // result stage: one run of bytes
  logic               out_valid_q;
  logic               zero_q;
  logic [3:0]         start_q;
  logic [3:0]         pcnt_q;
  logic               tailv_q;
  logic [7:0]         tail_q;
  logic               bend_q;
  logic               ureq_q;
  logic [LEN_W-1:0]   olen_q;
  logic [3:0]         pos_q;

  kind_e              kind;
  logic [7:0]         c;
  logic               last;
  logic               accept;
  logic               emit;
  logic               last_beat;
  logic [3:0]         total;
  logic               wr_en;

  logic [3:0]         mc, hc, mc1, hc1;
  logic               hit;
  logic               end_mark;

  logic               d_zero;
  logic [3:0]         d_start;
  logic [3:0]         d_pcnt;
  logic               d_tailv;

  assign kind     = kind_e'(req_i.kind);
  assign c        = req_i.data_byte;
  assign last     = req_i.buffer_last;
  assign end_mark = (c == CH_LF) || (c == CH_CR) || (c == CH_NUL);

  assign total     = pcnt_q + {3'b000, tailv_q};
  assign last_beat = (pos_q == total - 4'd1);

  // take a request when the stage is empty or its run finishes this cycle
  assign req_i.ready = !out_valid_q || (res_o.ready && last_beat);
  assign accept      = req_i.valid && req_i.ready;
  assign emit        = (d_pcnt != 4'd0) || d_tailv;

  always_comb begin
    mode_d     = mode_q;
    mc_d       = mc_q;
    held_d     = held_q;
    len_d      = len_q;
    req_flag_d = req_flag_q;
    wr_en      = 1'b0;
    d_zero     = 1'b0;
    d_start    = 4'd0;
    d_pcnt     = 4'd0;
    d_tailv    = 1'b0;

    mc  = (mc_q >= 4'(KEY_LEN)) ? 4'd0 : mc_q;
    hc  = (held_q > mc) ? mc : held_q;
    hit = (c == prefix_char(mc));
    mc1 = mc + 4'd1;
    hc1 = (mc == 4'd0) ? 4'd1 : hc + 4'd1;

    case (kind)
      KIND_READ: begin
        d_zero  = !(CMP_W'(req_i.secret_index) < CMP_W'(len_q));
        d_tailv = 1'b1;
      end
      KIND_RELEASE: begin
        len_d      = '0;
        req_flag_d = 1'b0;
        d_zero     = 1'b1;
        d_tailv    = 1'b1;
      end
      KIND_WRITE: begin
        case (mode_q)
          MODE_CAPTURE: begin
            d_tailv = 1'b1;
            if (end_mark) begin
              if (len_q == '0) begin
                len_d  = '0;
                mc_d   = 4'd0;
                held_d = 4'd0;
              end else begin
                req_flag_d = 1'b1;
                mc_d       = 4'd0;
              end
              mode_d = last ? MODE_SCAN : MODE_PASS;
            end else if (len_q >= LEN_W'(SECRET_CAP)) begin
              // overflow: drop the secret, pass the byte
              len_d  = '0;
              mc_d   = 4'd0;
              held_d = 4'd0;
              mode_d = last ? MODE_SCAN : MODE_PASS;
            end else begin
              wr_en  = 1'b1;
              d_zero = 1'b1;
              len_d  = len_q + LEN_W'(1);
              if (last && (len_q == LEN_W'(SECRET_CAP - 1))) begin
                len_d  = '0;
                mc_d   = 4'd0;
                held_d = 4'd0;
                mode_d = MODE_SCAN;
              end
            end
          end
          MODE_PASS: begin
            d_tailv = 1'b1;
            if (last) begin
              mode_d = MODE_SCAN;
            end
          end
          default: begin
            mode_d = MODE_SCAN;
            if (hit) begin
              if (mc1 == 4'(KEY_LEN)) begin
                // prefix complete: held bytes leave as zeros
                d_zero = 1'b1;
                d_pcnt = hc1;
                mc_d   = 4'd0;
                held_d = 4'd0;
                len_d  = '0;
                mode_d = MODE_CAPTURE;
              end else if (last) begin
                d_start = mc1 - hc1;
                d_pcnt  = hc1;
                mc_d    = mc1;
                held_d  = 4'd0;
              end else begin
                mc_d   = mc1;
                held_d = hc1;
              end
            end else begin
              // release held bytes unchanged, then restart
              d_start = mc - hc;
              d_pcnt  = hc;
              if (c == prefix_char(4'd0)) begin
                mc_d   = 4'd1;
                held_d = 4'd1;
                if (last) begin
                  d_tailv = 1'b1;
                  held_d  = 4'd0;
                end
              end else begin
                mc_d    = 4'd0;
                held_d  = 4'd0;
                d_tailv = 1'b1;
              end
            end
          end
        endcase
      end
      default: begin
        d_zero  = 1'b1;
        d_tailv = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_SCAN;
      mc_q       <= 4'd0;
      held_q     <= 4'd0;
      len_q      <= '0;
      req_flag_q <= 1'b0;
    end else if (accept) begin
      mode_q     <= mode_d;
      mc_q       <= mc_d;
      held_q     <= held_d;
      len_q      <= len_d;
      req_flag_q <= req_flag_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_q       <= 4'd0;
    end else if (accept) begin
      out_valid_q <= emit;
      pos_q       <= 4'd0;
    end else if (out_valid_q && res_o.ready) begin
      if (last_beat) begin
        out_valid_q <= 1'b0;
      end else begin
        pos_q <= pos_q + 4'd1;
      end
    end
  end

  // run descriptor; a readback takes its byte straight from the store
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      zero_q  <= d_zero;
      start_q <= d_start;
      pcnt_q  <= d_pcnt;
      tailv_q <= d_tailv;
      bend_q  <= (kind == KIND_WRITE) && last;
      ureq_q  <= req_flag_d;
      olen_q  <= len_d;
      if (kind == KIND_READ) begin
        tail_q <= mem[ADDR_W'(req_i.secret_index)];
      end else begin
        tail_q <= c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && wr_en) begin
      mem[len_q[ADDR_W-1:0]] <= c;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.out_byte       = zero_q ? 8'h00 :
                                (pos_q < pcnt_q) ? prefix_char(start_q + pos_q) : tail_q;
  assign res_o.run_last       = last_beat;
  assign res_o.buffer_end     = last_beat && bend_q;
  assign res_o.unlock_request = ureq_q;
  assign res_o.secret_length  = 8'(olen_q);

  `PKSC_ASSERT_IMPL(a_pos_in_run, out_valid_q, pos_q < total, "beat position beyond run")
  `PKSC_ASSERT_IMPL(a_run_blocks, out_valid_q && !last_beat, !req_i.ready,
                    "request taken while a run is still draining")
  `PKSC_ASSERT_IMPL(a_held_bound, 1'b1, (held_q <= mc_q) && (mc_q < 4'(KEY_LEN)),
                    "held count or match count out of range")
  `PKSC_ASSERT_IMPL(a_len_bound, 1'b1, len_q <= LEN_W'(SECRET_CAP),
                    "stored length beyond capacity")
  `PKSC_ASSERT_NEXT(a_silent_drop, accept && !emit, !out_valid_q,
                    "held byte left a result in the stage")

endmodule

@@ test/scrub_checker.sv @@
// Checker for the prefix-keyed secret capture block: watches both channels, predicts
// the scrubbed output stream and compares it field by field.
// Depends on pksc_pkg, pksc_req_if and pksc_res_if.
`timescale 1ns / 1ps
module scrub_checker (
  input  logic clk_i,
  input  logic rst_ni,
  pksc_req_if  req_i,
  pksc_res_if  res_i,
  output int   mismatch_count_o,
  output int   pending_o
);
  import pksc_pkg::*;

  localparam logic [8*KEY_LEN-1:0] KEY_TEXT = "password:";
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       buffer_end;
    logic       unlock_request;
    logic [7:0] secret_length;
  } scrub_result_t;

  scrub_result_t scrubbed_q[$];

  logic [3:0]  match_cnt;
  logic [3:0]  held_cnt;
  mode_e       scan_state;
  logic [7:0]  secret_mem [SECRET_CAP];
  int unsigned secret_len;
  logic        unlock_flag;

  function automatic logic [7:0] key_char(input int pos);
    return KEY_TEXT[8*(KEY_LEN-1-pos) +: 8];
  endfunction

  function automatic void forget_secret();
    secret_len = 0;
    match_cnt  = '0;
    held_cnt   = '0;
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatch_count_o < MAX_PRINTED) begin
      $display("%0t ns: mismatch on %s, got %0h, want %0h", $time, field, got, want);
    end
    mismatch_count_o++;
  endtask

  // Work out every result one request causes and queue them in order
  task automatic scrub_and_capture(input logic [1:0] kind, input logic [7:0] data,
                                   input logic last, input logic [6:0] idx);
    logic [7:0]    outs [KEY_LEN+1];
    int            n;
    int            k;
    scrub_result_t r;
    n = 0;
    case (kind)
      KIND_READ: begin
        outs[0] = (idx < secret_len) ? secret_mem[idx] : 8'h00;
        n = 1;
      end
      KIND_RELEASE: begin
        secret_len  = 0;
        unlock_flag = 1'b0;
        outs[0]     = 8'h00;
        n = 1;
      end
      KIND_NOP: begin
        outs[0] = 8'h00;
        n = 1;
      end
      default: begin
        if (scan_state == MODE_CAPTURE) begin
          if (data == CH_NUL || data == CH_LF || data == CH_CR) begin
            if (secret_len == 0) begin
              forget_secret();
            end else begin
              unlock_flag = 1'b1;
              match_cnt   = '0;
            end
            scan_state = last ? MODE_SCAN : MODE_PASS;
            outs[0] = data;
          end else if (secret_len >= SECRET_CAP) begin
            forget_secret();
            scan_state = last ? MODE_SCAN : MODE_PASS;
            outs[0] = data;
          end else begin
            secret_mem[secret_len] = data;
            secret_len++;
            // a buffer that closes exactly at capacity loses the secret
            if (last && secret_len >= SECRET_CAP) begin
              forget_secret();
              scan_state = MODE_SCAN;
            end
            outs[0] = 8'h00;
          end
          n = 1;
        end else if (scan_state == MODE_PASS) begin
          outs[0] = data;
          n = 1;
          if (last) scan_state = MODE_SCAN;
        end else begin
          scan_state = MODE_SCAN;
          if (match_cnt >= KEY_LEN) match_cnt = '0;
          if (held_cnt > match_cnt) held_cnt = match_cnt;
          if (data == key_char(int'(match_cnt))) begin
            if (match_cnt == 0) held_cnt = '0;
            match_cnt++;
            held_cnt++;
            if (match_cnt == KEY_LEN) begin
              for (k = 0; k < int'(held_cnt); k++) begin
                outs[n] = 8'h00;
                n++;
              end
              match_cnt  = '0;
              held_cnt   = '0;
              secret_len = 0;
              scan_state = MODE_CAPTURE;
            end else if (last) begin
              for (k = int'(match_cnt) - int'(held_cnt); k < int'(match_cnt); k++) begin
                outs[n] = key_char(k);
                n++;
              end
              held_cnt = '0;
            end
          end else begin
            // release what was held, then restart the match
            for (k = int'(match_cnt) - int'(held_cnt); k < int'(match_cnt); k++) begin
              outs[n] = key_char(k);
              n++;
            end
            if (data == key_char(0)) begin
              match_cnt = 4'd1;
              held_cnt  = 4'd1;
              if (last) begin
                outs[n] = data;
                n++;
                held_cnt = '0;
              end
            end else begin
              match_cnt = '0;
              held_cnt  = '0;
              outs[n] = data;
              n++;
            end
          end
        end
      end
    endcase
    for (k = 0; k < n; k++) begin
      r.out_byte       = outs[k];
      r.run_last       = (k == n - 1);
      r.buffer_end     = (k == n - 1) && last && (kind == KIND_WRITE);
      r.unlock_request = unlock_flag;
      r.secret_length  = 8'(secret_len);
      scrubbed_q.push_back(r);
    end
  endtask

  task automatic check_result();
    scrub_result_t want;
    if (scrubbed_q.size() == 0) begin
      report_mismatch("result with nothing pending", res_i.out_byte, 8'h00);
    end else begin
      want = scrubbed_q.pop_front();
      if (res_i.out_byte !== want.out_byte)
        report_mismatch("out_byte", res_i.out_byte, want.out_byte);
      if (res_i.run_last !== want.run_last)
        report_mismatch("run_last", 8'(res_i.run_last), 8'(want.run_last));
      if (res_i.buffer_end !== want.buffer_end)
        report_mismatch("buffer_end", 8'(res_i.buffer_end), 8'(want.buffer_end));
      if (res_i.unlock_request !== want.unlock_request)
        report_mismatch("unlock_request", 8'(res_i.unlock_request),
                        8'(want.unlock_request));
      if (res_i.secret_length !== want.secret_length)
        report_mismatch("secret_length", res_i.secret_length, want.secret_length);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_cnt        = '0;
      held_cnt         = '0;
      scan_state       = MODE_SCAN;
      secret_len       = 0;
      unlock_flag      = 1'b0;
      mismatch_count_o = 0;
      scrubbed_q.delete();
      pending_o <= 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        scrub_and_capture(req_i.kind, req_i.data_byte, req_i.buffer_last,
                          req_i.secret_index);
      end
      if (res_i.valid && res_i.ready) check_result();
      pending_o <= scrubbed_q.size();
    end
  end

endmodule

@@ test/testbench.sv @@
// Top of the prefix-keyed secret capture testbench: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on pksc_pkg, both channel
// interfaces, the block itself and scrub_checker.
`timescale 1ns / 1ps
module testbench;
  import pksc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 200;
  localparam int ITEM_COUNT  = 470;
  localparam int TAIL_CYCLES = 20;

  logic  clk_i    = 1'b0;
  logic  rst_ni   = 1'b0;
  int    mismatches;
  int    pending;
  int    sent     = 0;
  bit    calm     = 1'b0;
  bit    hold_off = 1'b0;
  string key_word = "password:";

  pksc_req_if req_if ();
  pksc_res_if res_if ();

  prefix_keyed_secret_capture u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  scrub_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req_if),
    .res_i            (res_if),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always #4 clk_i = ~clk_i;

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request, none near the end
  initial begin : result_pacing
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  task automatic send(input kind_e kind, input logic [7:0] data, input logic last,
                      input logic [6:0] idx);
    // no idling over the last stretch of requests
    if (sent >= ITEM_COUNT - 70) calm = 1'b1;
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.kind         <= kind;
    req_if.data_byte    <= data;
    req_if.buffer_last  <= last;
    req_if.secret_index <= idx;
    do @(posedge clk_i); while (!req_if.ready);
    sent++;
  endtask

  task automatic put_byte(input logic [7:0] data, input logic last);
    send(KIND_WRITE, data, last, 7'($urandom));
  endtask

  task automatic ask(input kind_e kind, input logic [6:0] idx);
    send(kind, 8'($urandom), 1'($urandom), idx);
  endtask

  // Hold the request side until every queued result has left
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_NUL || b == CH_LF || b == CH_CR);
    return b;
  endfunction

  // Bytes that often look like part of the prefix
  function automatic logic [7:0] lure_byte();
    logic [7:0] b;
    if ($urandom_range(0, 1) == 0) b = key_word[$urandom_range(0, KEY_LEN - 1)];
    else b = 8'($urandom);
    return b;
  endfunction

  function automatic logic [7:0] end_mark();
    logic [7:0] b;
    case ($urandom_range(0, 2))
      0:       b = CH_NUL;
      1:       b = CH_LF;
      default: b = CH_CR;
    endcase
    return b;
  endfunction

  // split: position that closes the buffer; bad: position replaced by noise
  task automatic put_prefix(input int split, input int bad);
    logic [7:0] b;
    for (int k = 0; k < KEY_LEN; k++) begin
      b = (k == bad) ? 8'($urandom) : 8'(key_word[k]);
      put_byte(b, k == split);
    end
  endtask

  task automatic read_burst();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      if ($urandom_range(0, 9) < 7) ask(KIND_READ, 7'($urandom_range(0, 15)));
      else ask(KIND_READ, 7'($urandom));
    end
  endtask

  // Secret right at capacity, then a terminator, an overflowing byte or buffer end
  task automatic fill_secret(input bit last_on_fill, input bit with_tail,
                             input logic [7:0] tail);
    put_byte(CH_LF, 1'b1);
    put_prefix(KEY_LEN, KEY_LEN);
    for (int k = 1; k <= SECRET_CAP; k++) begin
      put_byte(plain_byte(), last_on_fill && k == SECRET_CAP);
    end
    if (with_tail) put_byte(tail, 1'b1);
    ask(KIND_READ, 7'd127);
    ask(KIND_READ, 7'($urandom));
  endtask

  task automatic capture_run();
    int   split;
    int   bad;
    int   secret_n;
    int   trail_n;
    bit   open_end;
    logic end_last;
    logic [7:0] b;
    if ($urandom_range(0, 9) < 6) put_byte(CH_LF, 1'b1);
    repeat ($urandom_range(0, 2)) put_byte(lure_byte(), 1'b0);
    split = ($urandom_range(0, 3) == 0) ? $urandom_range(0, KEY_LEN - 1) : KEY_LEN;
    bad   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, KEY_LEN - 1) : KEY_LEN;
    put_prefix(split, bad);
    case ($urandom_range(0, 9))
      0:       secret_n = 0;
      1, 2:    secret_n = $urandom_range(7, 24);
      default: secret_n = $urandom_range(1, 6);
    endcase
    open_end = ($urandom_range(0, 3) == 0) && secret_n > 0;
    for (int k = 0; k < secret_n; k++) begin
      b = ($urandom_range(0, 19) == 0) ? 8'($urandom) : plain_byte();
      put_byte(b, open_end && k == secret_n - 1);
    end
    // an open end leaves capture running into the next buffer
    if (!open_end) begin
      end_last = 1'($urandom);
      put_byte(end_mark(), end_last);
      if (!end_last) begin
        trail_n = $urandom_range(0, 3);
        for (int j = 0; j < trail_n; j++) put_byte(lure_byte(), j == trail_n - 1);
      end
    end
    if ($urandom_range(0, 9) < 3) read_burst();
  endtask

  task automatic noise_run();
    int n;
    n = $urandom_range(1, 6);
    for (int j = 0; j < n; j++) begin
      put_byte(lure_byte(), j == n - 1 && $urandom_range(0, 9) < 7);
    end
  endtask

  initial begin : stimulus
    int seq;
    int pick;
    req_if.valid        <= 1'b0;
    req_if.kind         <= KIND_WRITE;
    req_if.data_byte    <= 8'h00;
    req_if.buffer_last  <= 1'b0;
    req_if.secret_index <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(KIND_NOP, 8'hFF, 1'b1, 7'h7F);
    send(KIND_READ, 8'h00, 1'b0, 7'h7F);
    send(KIND_RELEASE, 8'hA5, 1'b1, 7'h00);
    put_byte(8'hFF, 1'b0);
    put_byte(CH_NUL, 1'b1);
    put_prefix(KEY_LEN, KEY_LEN);
    put_byte(8'h80, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h01, 1'b0);
    // terminator mid-buffer: the trailing 'p' must pass unscanned
    put_byte(CH_CR, 1'b0);
    put_byte(8'h70, 1'b1);
    ask(KIND_READ, 7'd0);
    ask(KIND_READ, 7'd2);
    ask(KIND_READ, 7'd3);
    ask(KIND_READ, 7'h7F);
    ask(KIND_RELEASE, 7'($urandom));

    seq = 0;
    while (sent < ITEM_COUNT) begin
      if (seq == 4) hold_off = 1'b1;
      if (seq == 6) drain();
      if (seq == 1 || seq == 4 || seq == 7) begin
        case (seq)
          1:       fill_secret(1'b0, 1'b1, CH_LF);
          4:       fill_secret(1'b0, 1'b1, 8'h5A);
          default: fill_secret(1'b1, 1'b0, CH_NUL);
        endcase
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40) capture_run();
        else if (pick < 60) read_burst();
        else if (pick < 68) ask(KIND_RELEASE, 7'($urandom));
        else if (pick < 72) ask(KIND_NOP, 7'($urandom));
        else noise_run();
      end
      seq++;
    end
    // close the buffer so no prefix bytes stay held
    put_byte(8'($urandom), 1'b1);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/pksc_pkg.sv
src/pksc_req_if.sv
src/pksc_res_if.sv
src/prefix_keyed_secret_capture.sv
test/scrub_checker.sv
test/testbench.sv
